### rtl/core/blmc_pkg.sv
// ----------------------------------------------------------------------------
// Button light mode controller package
// Shared types, constants and helper functions for the light controller.
// ----------------------------------------------------------------------------
`default_nettype none

package blmc_pkg;

    localparam int COLOR_W       = 5;
    localparam int COUNT_W       = 16;
    localparam int CMD_W         = 2;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;
    localparam int SLOT_COUNT    = 3;
    localparam int COLOR_COUNT_D = 32;

    localparam logic [COUNT_W-1:0] PERIOD_HIGH    = 16'd200;
    localparam logic [COUNT_W-1:0] PERIOD_LOW     = 16'd20;
    localparam logic [COUNT_W-1:0] PERIOD_BLINK   = 16'd600;
    localparam logic [COUNT_W-1:0] LOW_ON_TICKS   = 16'd2;
    localparam logic [COUNT_W-1:0] BLINK_ON_TICKS = 16'd20;
    localparam logic [COUNT_W-1:0] CONFIG_RESUME  = 16'd1000;
    localparam logic [COUNT_W-1:0] COUNT_MAX      = 16'hFFFF;

    localparam logic [COUNT_W-1:0] LONG_PRESS_RST  = 16'd6000;
    localparam logic [COUNT_W-1:0] SLEEP_DELAY_RST = 16'd1000;
    localparam logic [COUNT_W-1:0] CONFIG_HOLD_RST = 16'd2000;
    localparam logic [COLOR_W-1:0] START_A_RST     = 5'd0;
    localparam logic [COLOR_W-1:0] START_B_RST     = 5'd0;
    localparam logic [COLOR_W-1:0] START_C_RST     = 5'd0;

    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLEEP_DELAY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CONFIG_HOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_A     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_START_B     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_START_C     = 3'd5;

    localparam logic [CMD_W-1:0] CMD_NONE    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_STANDBY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FLASH   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_STORE   = 2'd3;

    localparam logic [1:0] PHASE_IDLE  = 2'd0;
    localparam logic [1:0] PHASE_PRESS = 2'd1;
    localparam logic [1:0] PHASE_HOLD  = 2'd2;

    localparam logic [1:0] SLOT_LAST = 2'd2;

    typedef enum logic [5:0] {
        MODE_OFF       = 6'b000001,
        MODE_HIGH      = 6'b000010,
        MODE_HIGH_HELD = 6'b000100,
        MODE_LOW       = 6'b001000,
        MODE_BLINK     = 6'b010000,
        MODE_CONFIG    = 6'b100000
    } t_mode;

    typedef struct packed {
        t_mode              mode;
        logic [1:0]         phase;
        logic [COUNT_W-1:0] tick;
        logic [COUNT_W-1:0] press;
        logic [1:0]         slot;
        logic               pending;
    } t_state;

    typedef struct packed {
        logic [COUNT_W-1:0] long_press;
        logic [COUNT_W-1:0] sleep_delay;
        logic [COUNT_W-1:0] config_hold;
    } t_cfg;

    typedef logic [SLOT_COUNT-1:0][COLOR_W-1:0] t_palette;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        sat_inc = (v == COUNT_MAX) ? v : v + 16'd1;
    endfunction

    function automatic logic [1:0] slot_next(input logic [1:0] s);
        case (s)
            2'd0:    slot_next = 2'd1;
            2'd1:    slot_next = 2'd2;
            2'd2:    slot_next = 2'd0;
            default: slot_next = 2'd1;
        endcase
    endfunction

endpackage

`default_nettype wire

### rtl/core/blmc_step.sv
// ----------------------------------------------------------------------------
// Button light mode controller step logic
// Next state, palette and result for one render tick or button sample.
// ----------------------------------------------------------------------------
`default_nettype none

module blmc_step #(
    parameter int COLOR_COUNT = blmc_pkg::COLOR_COUNT_D
) (
    input  wire blmc_pkg::t_state                 i_state,
    input  wire blmc_pkg::t_palette               i_palette,
    input  wire blmc_pkg::t_cfg                   i_cfg,
    input  wire                                   i_kind,
    input  wire                                   i_pressed,
    output blmc_pkg::t_state                      o_state,
    output blmc_pkg::t_palette                    o_palette,
    output logic                                  o_lit,
    output logic [blmc_pkg::COLOR_W-1:0]          o_color,
    output logic [blmc_pkg::CMD_W-1:0]            o_cmd
);

    logic                              use_period;
    logic [blmc_pkg::COUNT_W-1:0]      period;
    logic                              on;
    logic                              inc_press;
    logic [blmc_pkg::COLOR_W:0]        sum;
    logic [blmc_pkg::COLOR_W-1:0]      bumped;

    always_comb begin
        sum = {1'b0, i_palette[i_state.slot]} + 6'd1;
        if (9'(sum) == 9'(COLOR_COUNT)) begin
            bumped = '0;
        end else begin
            bumped = sum[blmc_pkg::COLOR_W-1:0];
        end
    end

    always_comb begin
        o_state    = i_state;
        o_palette  = i_palette;
        o_lit      = 1'b0;
        o_color    = '0;
        o_cmd      = blmc_pkg::CMD_NONE;
        use_period = 1'b0;
        period     = blmc_pkg::PERIOD_HIGH;
        on         = 1'b0;
        inc_press  = 1'b1;
        if (!i_kind) begin
            case (i_state.mode)
                blmc_pkg::MODE_HIGH_HELD, blmc_pkg::MODE_HIGH: begin
                    use_period = 1'b1;
                    period     = blmc_pkg::PERIOD_HIGH;
                end
                blmc_pkg::MODE_LOW: begin
                    use_period = 1'b1;
                    period     = blmc_pkg::PERIOD_LOW;
                end
                blmc_pkg::MODE_BLINK: begin
                    use_period = 1'b1;
                    period     = blmc_pkg::PERIOD_BLINK;
                end
                default: begin
                    use_period = 1'b0;
                end
            endcase
            if (use_period && (i_state.tick >= period)) begin
                o_state.slot = blmc_pkg::slot_next(i_state.slot);
                o_state.tick = '0;
            end
            case (i_state.mode)
                blmc_pkg::MODE_HIGH_HELD: on = 1'b1;
                blmc_pkg::MODE_HIGH:      on = (i_state.phase == blmc_pkg::PHASE_IDLE);
                blmc_pkg::MODE_LOW: begin
                    on = (o_state.tick < blmc_pkg::LOW_ON_TICKS) &&
                         (i_state.phase == blmc_pkg::PHASE_IDLE);
                end
                blmc_pkg::MODE_BLINK: begin
                    on = (o_state.tick < blmc_pkg::BLINK_ON_TICKS) &&
                         (i_state.phase == blmc_pkg::PHASE_IDLE);
                end
                blmc_pkg::MODE_CONFIG:    on = 1'b1;
                default:                  on = 1'b0;
            endcase
            o_state.tick = blmc_pkg::sat_inc(o_state.tick);
            if (on && (o_state.slot != 2'd3)) begin
                o_lit   = 1'b1;
                o_color = i_palette[o_state.slot];
            end
        end else begin
            case (i_state.mode)
                blmc_pkg::MODE_OFF: begin
                    if (i_pressed) begin
                        o_state.press = '0;
                        o_state.phase = blmc_pkg::PHASE_PRESS;
                        o_state.mode  = blmc_pkg::MODE_HIGH_HELD;
                    end else if (i_state.press > i_cfg.sleep_delay) begin
                        o_cmd     = blmc_pkg::CMD_STANDBY;
                        inc_press = 1'b0;
                    end
                end
                blmc_pkg::MODE_HIGH_HELD: begin
                    if (!i_pressed) begin
                        o_state.phase = blmc_pkg::PHASE_IDLE;
                        if (i_state.press >= i_cfg.long_press) begin
                            o_state.slot = '0;
                            o_state.mode = blmc_pkg::MODE_CONFIG;
                        end else begin
                            o_state.mode = blmc_pkg::MODE_HIGH;
                        end
                    end else if (i_state.press == i_cfg.long_press) begin
                        o_cmd = blmc_pkg::CMD_FLASH;
                    end
                end
                blmc_pkg::MODE_HIGH, blmc_pkg::MODE_LOW: begin
                    if (i_state.phase == blmc_pkg::PHASE_IDLE) begin
                        if (i_pressed) begin
                            o_state.phase   = blmc_pkg::PHASE_PRESS;
                            o_state.pending = (i_state.press >= i_cfg.long_press);
                        end
                    end else if (!i_pressed) begin
                        o_state.phase = blmc_pkg::PHASE_IDLE;
                        o_state.tick  = '0;
                        o_state.press = '0;
                        o_state.slot  = '0;
                        if (i_state.pending) begin
                            o_state.mode = blmc_pkg::MODE_OFF;
                        end else if (i_state.mode == blmc_pkg::MODE_HIGH) begin
                            o_state.mode = blmc_pkg::MODE_LOW;
                        end else begin
                            o_state.mode = blmc_pkg::MODE_BLINK;
                        end
                    end
                end
                blmc_pkg::MODE_BLINK: begin
                    if (i_state.phase == blmc_pkg::PHASE_IDLE) begin
                        if (i_pressed) begin
                            o_state.phase = blmc_pkg::PHASE_PRESS;
                        end
                    end else if (!i_pressed) begin
                        o_state.phase = blmc_pkg::PHASE_IDLE;
                        o_state.tick  = '0;
                        o_state.press = '0;
                        o_state.slot  = '0;
                        o_state.mode  = blmc_pkg::MODE_OFF;
                    end
                end
                default: begin
                    case (i_state.phase)
                        blmc_pkg::PHASE_IDLE: begin
                            if (i_pressed) begin
                                o_state.tick  = '0;
                                o_state.press = '0;
                                o_state.phase = blmc_pkg::PHASE_PRESS;
                            end
                        end
                        blmc_pkg::PHASE_PRESS: begin
                            if (!i_pressed) begin
                                if (i_state.slot != 2'd3) begin
                                    o_palette[i_state.slot] = bumped;
                                end
                                o_state.tick  = '0;
                                o_state.press = '0;
                                o_state.phase = blmc_pkg::PHASE_IDLE;
                            end else if (i_state.press >= i_cfg.config_hold) begin
                                o_state.press = blmc_pkg::CONFIG_RESUME;
                                o_state.phase = blmc_pkg::PHASE_HOLD;
                                o_cmd         = blmc_pkg::CMD_FLASH;
                                inc_press     = 1'b0;
                            end
                        end
                        blmc_pkg::PHASE_HOLD: begin
                            if (!i_pressed) begin
                                o_state.tick  = '0;
                                o_state.press = '0;
                                o_state.phase = blmc_pkg::PHASE_IDLE;
                                inc_press     = 1'b0;
                                if (i_state.slot == blmc_pkg::SLOT_LAST) begin
                                    o_state.mode = blmc_pkg::MODE_OFF;
                                    o_cmd        = blmc_pkg::CMD_STORE;
                                end else begin
                                    o_state.slot = i_state.slot + 2'd1;
                                end
                            end
                        end
                        default: begin
                            if (!i_pressed) begin
                                o_state.phase = blmc_pkg::PHASE_IDLE;
                            end
                        end
                    endcase
                end
            endcase
            if (inc_press) begin
                o_state.press = blmc_pkg::sat_inc(o_state.press);
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/button_light_mode_controller_top.sv
// ----------------------------------------------------------------------------
// Button light mode controller
// Single-button LED controller: render ticks give the lit flag and palette
// color, button samples run the mode machine and give a command.
//
//  Channel   Direction  Beat contents
//  s_axis    in         tuser: kind; tdata: pressed
//  m_axis    out        tdata: lit, color_index, command
//  cfg       in         index selects one of six registers, data is the value
//
// For every beat the step logic reads the state registers and the
// incoming beat and writes the next state and the result register at once.
// A new beat is accepted in every cycle while the result register is empty or
// being drained. Reset is synchronous and clears state, configuration and
// palette; the result register then holds no beat.
// ----------------------------------------------------------------------------
`default_nettype none

module button_light_mode_controller_top #(
    parameter int COLOR_COUNT = blmc_pkg::COLOR_COUNT_D
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_s_tvalid,
    output logic                               o_s_tready,
    input  wire  [7:0]                         i_s_tdata,   // [0] pressed
    input  wire  [0:0]                         i_s_tuser,   // [0] kind
    output logic                               o_m_tvalid,
    input  wire                                i_m_tready,
    output logic [7:0]                         o_m_tdata,   // [0] lit, [5:1] color_index, [7:6] command
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire  [blmc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire  [blmc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    blmc_pkg::t_state              r_state;
    blmc_pkg::t_state              n_state;
    blmc_pkg::t_palette            r_palette;
    blmc_pkg::t_palette            n_palette;
    blmc_pkg::t_cfg                r_cfg;
    logic                          r_out_valid;
    logic [7:0]                    r_out_data;
    logic                          n_lit;
    logic [blmc_pkg::COLOR_W-1:0]  n_color;
    logic [blmc_pkg::CMD_W-1:0]    n_cmd;
    logic                          in_accept;

    assign o_s_tready  = !r_out_valid || i_m_tready;
    assign o_cfg_ready = 1'b1;
    assign in_accept   = i_s_tvalid && o_s_tready;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;

    blmc_step #(
        .COLOR_COUNT (COLOR_COUNT)
    ) u_step (
        .i_state   (r_state),
        .i_palette (r_palette),
        .i_cfg     (r_cfg),
        .i_kind    (i_s_tuser[0]),
        .i_pressed (i_s_tdata[0]),
        .o_state   (n_state),
        .o_palette (n_palette),
        .o_lit     (n_lit),
        .o_color   (n_color),
        .o_cmd     (n_cmd)
    );

    // The start colors are not stored: the palette always reloads the reset
    // constants, and writes to their indices are accepted but ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.long_press  <= blmc_pkg::LONG_PRESS_RST;
            r_cfg.sleep_delay <= blmc_pkg::SLEEP_DELAY_RST;
            r_cfg.config_hold <= blmc_pkg::CONFIG_HOLD_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                blmc_pkg::REG_LONG_PRESS:  r_cfg.long_press  <= i_cfg_data;
                blmc_pkg::REG_SLEEP_DELAY: r_cfg.sleep_delay <= i_cfg_data;
                blmc_pkg::REG_CONFIG_HOLD: r_cfg.config_hold <= i_cfg_data;
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode    <= blmc_pkg::MODE_OFF;
            r_state.phase   <= blmc_pkg::PHASE_IDLE;
            r_state.tick    <= '0;
            r_state.press   <= '0;
            r_state.slot    <= '0;
            r_state.pending <= 1'b0;
            r_palette[0]    <= blmc_pkg::START_A_RST;
            r_palette[1]    <= blmc_pkg::START_B_RST;
            r_palette[2]    <= blmc_pkg::START_C_RST;
            r_out_valid     <= 1'b0;
        end else if (in_accept) begin
            r_state     <= n_state;
            r_palette   <= n_palette;
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_data <= {n_cmd, n_color, n_lit};
        end
    end

endmodule

`default_nettype wire

### bench/tb_button_light_mode_controller_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button light mode controller testbench
// Feeds render ticks and button gestures into the controller while both
// streams stall at random, predicts every result beat from a model of the
// mode machine and compares the beats field by field. Thresholds are changed
// between phases, from all zero to all maximum.
// ----------------------------------------------------------------------------

module tb_button_light_mode_controller_top;

    localparam bit KIND_TICK       = 1'b0;
    localparam bit KIND_BUTTON     = 1'b1;
    localparam int IDLE_PCT        = 7;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PHASE_ITEMS     = 90;

    typedef logic [blmc_pkg::COUNT_W-1:0]    t_count;
    typedef logic [blmc_pkg::COLOR_W-1:0]    t_color;
    typedef logic [blmc_pkg::CMD_W-1:0]      t_cmd;
    typedef logic [blmc_pkg::CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [blmc_pkg::CFG_DATA_W-1:0] t_cfg_word;

    typedef struct packed {
        t_cmd   command;
        t_color color_index;
        logic   lit;
    } t_light_beat;

    class t_scoreboard;
        blmc_pkg::t_mode mode;
        logic [1:0]      phase;
        t_count          tick;
        t_count          press;
        logic [1:0]      slot;
        bit              off_pending;
        t_count          long_press;
        t_count          sleep_delay;
        t_count          config_hold;
        t_color          start_color [blmc_pkg::SLOT_COUNT];
        t_color          palette [blmc_pkg::SLOT_COUNT];
        t_light_beat     expected_beats [$];
        int              checked;
        int              errors;
        int              lit_ticks;
        int              commands [4];

        function new();
            mode           = blmc_pkg::MODE_OFF;
            phase          = blmc_pkg::PHASE_IDLE;
            tick           = '0;
            press          = '0;
            slot           = '0;
            off_pending    = 1'b0;
            long_press     = blmc_pkg::LONG_PRESS_RST;
            sleep_delay    = blmc_pkg::SLEEP_DELAY_RST;
            config_hold    = blmc_pkg::CONFIG_HOLD_RST;
            start_color[0] = blmc_pkg::START_A_RST;
            start_color[1] = blmc_pkg::START_B_RST;
            start_color[2] = blmc_pkg::START_C_RST;
            for (int i = 0; i < blmc_pkg::SLOT_COUNT; i++) palette[i] = start_color[i];
            checked   = 0;
            errors    = 0;
            lit_ticks = 0;
            for (int i = 0; i < 4; i++) commands[i] = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, t_cfg_word val);
            case (idx)
                blmc_pkg::REG_LONG_PRESS:  long_press     = val;
                blmc_pkg::REG_SLEEP_DELAY: sleep_delay    = val;
                blmc_pkg::REG_CONFIG_HOLD: config_hold    = val;
                blmc_pkg::REG_START_A:     start_color[0] = val[blmc_pkg::COLOR_W-1:0];
                blmc_pkg::REG_START_B:     start_color[1] = val[blmc_pkg::COLOR_W-1:0];
                blmc_pkg::REG_START_C:     start_color[2] = val[blmc_pkg::COLOR_W-1:0];
                default: ;
            endcase
        endfunction

        function t_count bump(t_count v);
            return (v == blmc_pkg::COUNT_MAX) ? v : v + 16'd1;
        endfunction

        function void advance_slot(t_count period);
            if (tick >= period) begin
                slot = (slot == blmc_pkg::SLOT_LAST) ? 2'd0 : slot + 2'd1;
                tick = '0;
            end
        endfunction

        function t_light_beat render();
            t_light_beat b;
            bit          on;
            on = 1'b0;
            case (mode)
                blmc_pkg::MODE_HIGH_HELD: begin
                    advance_slot(blmc_pkg::PERIOD_HIGH);
                    on = 1'b1;
                end
                blmc_pkg::MODE_HIGH: begin
                    advance_slot(blmc_pkg::PERIOD_HIGH);
                    on = (phase == blmc_pkg::PHASE_IDLE);
                end
                blmc_pkg::MODE_LOW: begin
                    advance_slot(blmc_pkg::PERIOD_LOW);
                    on = (tick < blmc_pkg::LOW_ON_TICKS) && (phase == blmc_pkg::PHASE_IDLE);
                end
                blmc_pkg::MODE_BLINK: begin
                    advance_slot(blmc_pkg::PERIOD_BLINK);
                    on = (tick < blmc_pkg::BLINK_ON_TICKS) &&
                         (phase == blmc_pkg::PHASE_IDLE);
                end
                blmc_pkg::MODE_CONFIG: on = 1'b1;
                default: ;
            endcase
            tick          = bump(tick);
            b.lit         = on && (slot < blmc_pkg::SLOT_COUNT);
            b.color_index = b.lit ? palette[slot] : '0;
            b.command     = blmc_pkg::CMD_NONE;
            return b;
        endfunction

        function void cycle_mode(bit p, blmc_pkg::t_mode next_mode);
            if (phase == blmc_pkg::PHASE_IDLE) begin
                if (p) begin
                    phase       = blmc_pkg::PHASE_PRESS;
                    off_pending = (press >= long_press);
                end
            end else if (!p) begin
                phase = blmc_pkg::PHASE_IDLE;
                tick  = '0;
                press = '0;
                slot  = '0;
                mode  = off_pending ? blmc_pkg::MODE_OFF : next_mode;
            end
        endfunction

        function t_cmd button_step(bit p);
            case (mode)
                blmc_pkg::MODE_OFF: begin
                    if (p) begin
                        press = '0;
                        phase = blmc_pkg::PHASE_PRESS;
                        mode  = blmc_pkg::MODE_HIGH_HELD;
                    end else if (press > sleep_delay) begin
                        return blmc_pkg::CMD_STANDBY;
                    end
                end
                blmc_pkg::MODE_HIGH_HELD: begin
                    if (!p) begin
                        phase = blmc_pkg::PHASE_IDLE;
                        if (press >= long_press) begin
                            slot = '0;
                            mode = blmc_pkg::MODE_CONFIG;
                        end else begin
                            mode = blmc_pkg::MODE_HIGH;
                        end
                    end else if (press == long_press) begin
                        press = bump(press);
                        return blmc_pkg::CMD_FLASH;
                    end
                end
                blmc_pkg::MODE_HIGH: cycle_mode(p, blmc_pkg::MODE_LOW);
                blmc_pkg::MODE_LOW:  cycle_mode(p, blmc_pkg::MODE_BLINK);
                blmc_pkg::MODE_BLINK: begin
                    if (phase == blmc_pkg::PHASE_IDLE) begin
                        if (p) phase = blmc_pkg::PHASE_PRESS;
                    end else if (!p) begin
                        phase = blmc_pkg::PHASE_IDLE;
                        tick  = '0;
                        press = '0;
                        slot  = '0;
                        mode  = blmc_pkg::MODE_OFF;
                    end
                end
                default: begin
                    if (phase == blmc_pkg::PHASE_IDLE) begin
                        if (p) begin
                            tick  = '0;
                            press = '0;
                            phase = blmc_pkg::PHASE_PRESS;
                        end
                    end else if (phase == blmc_pkg::PHASE_PRESS) begin
                        if (!p) begin
                            if (slot < blmc_pkg::SLOT_COUNT)
                                palette[slot] = t_color'((int'(palette[slot]) + 1) %
                                                         blmc_pkg::COLOR_COUNT_D);
                            tick  = '0;
                            press = '0;
                            phase = blmc_pkg::PHASE_IDLE;
                        end else if (press >= config_hold) begin
                            press = blmc_pkg::CONFIG_RESUME;
                            phase = blmc_pkg::PHASE_HOLD;
                            return blmc_pkg::CMD_FLASH;
                        end
                    end else if (phase == blmc_pkg::PHASE_HOLD) begin
                        if (!p) begin
                            tick  = '0;
                            press = '0;
                            phase = blmc_pkg::PHASE_IDLE;
                            if (slot == blmc_pkg::SLOT_LAST) begin
                                mode = blmc_pkg::MODE_OFF;
                                return blmc_pkg::CMD_STORE;
                            end
                            slot = slot + 2'd1;
                            return blmc_pkg::CMD_NONE;
                        end
                    end else if (!p) begin
                        phase = blmc_pkg::PHASE_IDLE;
                    end
                end
            endcase
            press = bump(press);
            return blmc_pkg::CMD_NONE;
        endfunction

        function void note_beat(bit kind, bit level);
            t_light_beat b;
            if (kind == KIND_TICK) begin
                b = render();
            end else begin
                b         = '0;
                b.command = button_step(level);
            end
            expected_beats.push_back(b);
        endfunction

        function void check_beat(logic [7:0] tdata);
            t_light_beat got;
            t_light_beat want;
            got = t_light_beat'(tdata);
            if (expected_beats.size() == 0) begin
                $error("result beat 0x%02h arrived with nothing expected", tdata);
                errors++;
                return;
            end
            want = expected_beats.pop_front();
            checked++;
            if (got.lit !== want.lit) begin
                $error("lit mismatch: expected %0d, actual %0d", want.lit, got.lit);
                errors++;
            end
            if (got.color_index !== want.color_index) begin
                $error("color_index mismatch: expected %0d, actual %0d",
                       want.color_index, got.color_index);
                errors++;
            end
            if (got.command !== want.command) begin
                $error("command mismatch: expected %0d, actual %0d", want.command, got.command);
                errors++;
            end
            lit_ticks += want.lit;
            commands[want.command]++;
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_s_tvalid;
    logic [7:0] i_s_tdata;
    logic [0:0] i_s_tuser;
    logic       i_m_tready;
    logic       i_cfg_valid;
    t_cfg_idx   i_cfg_index;
    t_cfg_word  i_cfg_data;
    wire        o_s_tready;
    wire        o_m_tvalid;
    wire  [7:0] o_m_tdata;
    wire        o_cfg_ready;

    t_scoreboard model = new();
    bit idle_on  = 1'b1;
    bit hold_req = 1'b0;
    int hold_offs;
    int settings_run;

    button_light_mode_controller_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) model.check_beat(o_m_tdata);
            if (i_s_tvalid && o_s_tready) model.note_beat(i_s_tuser[0], i_s_tdata[0]);
        end
    end

    initial begin
        hold_offs = 0;
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_offs++;
            end
            i_m_tready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic send_beat(input bit kind, input bit level);
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= {7'd0, level};
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic tick_burst(input int count);
        repeat (count) send_beat(KIND_TICK, bit'($urandom_range(1)));
    endtask

    task automatic button_run(input bit level, input int count, input int tick_pct);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < tick_pct) tick_burst($urandom_range(1, 2));
            send_beat(KIND_BUTTON, level);
        end
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (model.pending() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic configure(input t_cfg_word long_v,
                             input t_cfg_word sleep_v,
                             input t_cfg_word hold_v);
        t_cfg_idx  regs [6];
        t_cfg_word vals [6];
        regs[0] = blmc_pkg::REG_LONG_PRESS;
        regs[1] = blmc_pkg::REG_SLEEP_DELAY;
        regs[2] = blmc_pkg::REG_CONFIG_HOLD;
        regs[3] = blmc_pkg::REG_START_A;
        regs[4] = blmc_pkg::REG_START_B;
        regs[5] = blmc_pkg::REG_START_C;
        vals[0] = long_v;
        vals[1] = sleep_v;
        vals[2] = hold_v;
        for (int r = 3; r < 6; r++) vals[r] = t_cfg_word'($urandom_range(31));
        for (int r = 0; r < 6; r++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= regs[r];
            i_cfg_data  <= vals[r];
            do @(posedge i_clk); while (!o_cfg_ready);
            model.write_reg(regs[r], vals[r]);
        end
        i_cfg_valid <= 1'b0;
        settings_run++;
    endtask

    function automatic int press_len();
        int n;
        case ($urandom_range(3))
            0:       n = $urandom_range(1, 2);
            1:       n = model.long_press + $urandom_range(0, 3);
            2:       n = model.config_hold + $urandom_range(0, 3);
            default: n = $urandom_range(1, 16);
        endcase
        return (n < 1) ? 1 : n;
    endfunction

    function automatic int release_len();
        int n;
        case ($urandom_range(3))
            0, 1:    n = $urandom_range(1, 2);
            2:       n = model.sleep_delay + $urandom_range(0, 3);
            default: n = $urandom_range(1, 8);
        endcase
        return (n < 1) ? 1 : n;
    endfunction

    task automatic random_phase(input int goal);
        int done;
        done = 0;
        while (done < goal) begin
            case ($urandom_range(9))
                0: begin
                    repeat ($urandom_range(1, 6)) begin
                        send_beat(bit'($urandom_range(1)), bit'($urandom_range(1)));
                        done++;
                    end
                end
                1: begin
                    int n;
                    case ($urandom_range(9))
                        0, 1, 2, 3, 4, 5: n = $urandom_range(1, 4);
                        6, 7, 8:          n = $urandom_range(5, 30);
                        default:          n = $urandom_range(190, 610);
                    endcase
                    tick_burst(n);
                    done += n;
                end
                default: begin
                    int np;
                    int nr;
                    np = press_len();
                    nr = release_len();
                    button_run(1'b1, np, 15);
                    button_run(1'b0, nr, 15);
                    done += np + nr;
                end
            endcase
        end
    endtask

    task automatic steer_to_off();
        int guard;
        guard = 0;
        drain();
        while (model.mode != blmc_pkg::MODE_OFF && guard < 12) begin
            button_run(1'b1, 3, 0);
            button_run(1'b0, 1, 0);
            drain();
            guard++;
        end
    endtask

    initial begin
        settings_run = 0;
        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tuser   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= blmc_pkg::REG_LONG_PRESS;
        i_cfg_data  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        configure(16'd3, 16'd2, 16'd2);
        send_beat(KIND_TICK, 1'b1);
        button_run(1'b0, 4, 0);
        button_run(1'b1, 1, 0);
        send_beat(KIND_TICK, 1'b0);
        button_run(1'b1, 3, 0);
        button_run(1'b0, 1, 0);
        send_beat(KIND_TICK, 1'b1);
        button_run(1'b1, 1, 0);
        button_run(1'b0, 1, 0);
        send_beat(KIND_TICK, 1'b0);
        repeat (3) begin
            button_run(1'b1, 3, 0);
            button_run(1'b0, 1, 0);
        end
        drain();

        configure(16'd0, 16'd0, 16'd0);
        random_phase(PHASE_ITEMS);
        drain();

        configure(t_cfg_word'($urandom_range(1, 8)), t_cfg_word'($urandom_range(0, 10)),
                  t_cfg_word'($urandom_range(0, 8)));
        hold_req = 1'b1;
        random_phase(PHASE_ITEMS);
        drain();

        idle_on = 1'b0;
        configure(t_cfg_word'($urandom_range(1, 8)), t_cfg_word'($urandom_range(0, 10)),
                  t_cfg_word'($urandom_range(0, 8)));
        random_phase(PHASE_ITEMS);
        drain();
        idle_on = 1'b1;

        for (int k = 0; k < 5; k++) begin
            configure(t_cfg_word'($urandom_range(1, 12)), t_cfg_word'($urandom_range(0, 12)),
                      t_cfg_word'($urandom_range(0, 10)));
            random_phase(PHASE_ITEMS);
            drain();
        end

        configure(16'd100, 16'd100, 16'd1);
        steer_to_off();
        configure(blmc_pkg::COUNT_MAX, blmc_pkg::COUNT_MAX, blmc_pkg::COUNT_MAX);
        button_run(1'b0, 5, 0);
        tick_burst(20);
        button_run(1'b1, 1, 0);
        button_run(1'b0, 1, 0);
        tick_burst(210);
        button_run(1'b1, 1, 0);
        button_run(1'b0, 1, 0);
        tick_burst(45);
        button_run(1'b1, 1, 0);
        button_run(1'b0, 1, 0);
        tick_burst(40);
        button_run(1'b1, 1, 0);
        button_run(1'b0, 1, 0);
        drain();
        configure(16'd4, blmc_pkg::COUNT_MAX, blmc_pkg::COUNT_MAX);
        button_run(1'b1, 8, 1);
        button_run(1'b0, 1, 0);
        tick_burst(5);
        repeat (3) begin
            button_run(1'b1, 1, 0);
            button_run(1'b0, 1, 30);
        end
        drain();

        $display("summary: %0d result beats checked over %0d register settings, %0d lit ticks",
                 model.checked, settings_run, model.lit_ticks);
        $display("summary: %0d standby, %0d flash, %0d store commands; %0d output hold-offs",
                 model.commands[blmc_pkg::CMD_STANDBY], model.commands[blmc_pkg::CMD_FLASH],
                 model.commands[blmc_pkg::CMD_STORE], hold_offs);
        if (model.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #500_000;
        $error("run did not complete within the time limit");
        $display("status: fail");
        $finish;
    end

endmodule
